// ===== src/la32r_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package la32r_pkg;

  localparam int TlbIndexBits = 16;
  localparam int PhysAddrBits = 36;
  localparam int TimerBits    = 31;

  localparam logic [31:0] RESET_PC    = 32'h1c00_0000;
  localparam logic [31:0] CRMD_RESET  = 32'h0000_0008;
  localparam logic [4:0]  CSR_SLOT_CRMD = 5'd0;
  localparam logic [4:0]  CSR_SLOT_TID  = 5'd21;

  localparam logic [63:0] ELO_LOW   = (64'd1 << (PhysAddrBits - 4)) - 64'd1;
  localparam logic [31:0] ELO_MASK  = (ELO_LOW[31:0] & 32'hffff_ff00) | 32'h0000_007f;
  localparam logic [63:0] TLBI_LOW  = (64'd1 << TlbIndexBits) - 64'd1;
  localparam logic [31:0] TLBI_MASK = 32'hbf00_0000 | TLBI_LOW[31:0];
  localparam logic [63:0] TVAL_LOW  = (64'd1 << TimerBits) - 64'd1;
  localparam logic [31:0] TCFG_MASK = TVAL_LOW[31:0];

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNSUP   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_BADCSR  = 2'd3;

  typedef struct packed {
    logic start;
    logic is_signed;
    logic want_mod;
  } div_req_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] slot;
  } csr_hit_t;

  function automatic csr_hit_t csr_lookup(input logic [13:0] addr);
    csr_hit_t r;
    r.hit = 1'b1;
    case (addr)
      14'h000: r.slot = 5'd0;
      14'h001: r.slot = 5'd1;
      14'h002: r.slot = 5'd2;
      14'h004: r.slot = 5'd3;
      14'h005: r.slot = 5'd4;
      14'h006: r.slot = 5'd5;
      14'h007: r.slot = 5'd6;
      14'h00c: r.slot = 5'd7;
      14'h010: r.slot = 5'd8;
      14'h011: r.slot = 5'd9;
      14'h012: r.slot = 5'd10;
      14'h013: r.slot = 5'd11;
      14'h018: r.slot = 5'd12;
      14'h019: r.slot = 5'd13;
      14'h01a: r.slot = 5'd14;
      14'h01b: r.slot = 5'd15;
      14'h020: r.slot = 5'd16;
      14'h030: r.slot = 5'd17;
      14'h031: r.slot = 5'd18;
      14'h032: r.slot = 5'd19;
      14'h033: r.slot = 5'd20;
      14'h040: r.slot = 5'd21;
      14'h041: r.slot = 5'd22;
      14'h042: r.slot = 5'd23;
      14'h044: r.slot = 5'd24;
      14'h060: r.slot = 5'd25;
      14'h088: r.slot = 5'd26;
      14'h098: r.slot = 5'd27;
      14'h180: r.slot = 5'd28;
      14'h181: r.slot = 5'd29;
      default: begin
        r.hit  = 1'b0;
        r.slot = 5'd0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] csr_wmask(input logic [4:0] slot);
    logic [31:0] m;
    case (slot)
      5'd0:  m = 32'h0000_01ff;
      5'd1:  m = 32'h0000_0007;
      5'd2:  m = 32'h0000_0001;
      5'd3:  m = 32'h0000_1bff;
      5'd4:  m = 32'h0000_0003;
      5'd5:  m = 32'hffff_ffff;
      5'd6:  m = 32'hffff_ffff;
      5'd7:  m = 32'hffff_ffc0;
      5'd8:  m = TLBI_MASK;
      5'd9:  m = 32'hffff_e000;
      5'd10: m = ELO_MASK;
      5'd11: m = ELO_MASK;
      5'd12: m = 32'h0000_03ff;
      5'd13: m = 32'hffff_f000;
      5'd14: m = 32'hffff_f000;
      5'd17: m = 32'hffff_ffff;
      5'd18: m = 32'hffff_ffff;
      5'd19: m = 32'hffff_ffff;
      5'd20: m = 32'hffff_ffff;
      5'd21: m = 32'hffff_ffff;
      5'd22: m = TCFG_MASK;
      5'd25: m = 32'h0000_0004;
      5'd26: m = 32'hffff_ffc0;
      5'd28: m = 32'hee00_0039;
      5'd29: m = 32'hee00_0039;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== src/la32r_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module la32r_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/la32r_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module la32r_div
  import la32r_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire div_req_t    req_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      result_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        done_q;
  logic [31:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic        negq_q, negr_q, mod_q;
  logic [32:0] shifted, diff;

  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (req_i.start) begin
      cnt_d = 6'd32;
      quo_d = (req_i.is_signed && dividend_i[31]) ? 32'd0 - dividend_i : dividend_i;
      rem_d = 32'd0;
      dvs_d = (req_i.is_signed && divisor_i[31]) ? 32'd0 - divisor_i : divisor_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (!diff[32]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 6'd0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= !req_i.start && (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    if (req_i.start) begin
      negq_q <= req_i.is_signed && (dividend_i[31] ^ divisor_i[31]);
      negr_q <= req_i.is_signed && dividend_i[31];
      mod_q  <= req_i.want_mod;
    end
  end

  assign done_o   = done_q;
  assign result_o = mod_q ? (negr_q ? 32'd0 - rem_q : rem_q)
                          : (negq_q ? 32'd0 - quo_q : quo_q);

endmodule
`default_nettype wire

// ===== src/la32r_integer_execute_unit.sv =====
// LoongArch32-reduced integer execute unit.
// Input channel s_axis: one 32-bit instruction item, taken while the unit is
// idle. Output channel m_axis: one result item per instruction carrying status,
// register write-back and next pc.
// The general registers and the CSR file each sit in a 32-entry synchronous
// RAM with one read port; rj, rk and rd are read one after another, then the
// instruction executes and writes back.
// An instruction steps through the reads of rj, rk and rd, the execute step,
// a multiply or divide step where needed, and the write-back step; divides wait
// on the 32-step radix-2 divider.
// A new instruction is taken only after the previous one leaves write-back.
// A new instruction is accepted while a finished result waits in the output
// register; if the receiver stalls, the next instruction finishes execution
// and holds in the write-back step until the output register frees.
// Reset: r1..r31 read zero, pc is 0x1c000000, CSRs read zero except CRMD = 8;
// per-entry valid flags cleared at reset stand in for the RAM contents, so
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module la32r_integer_execute_unit
  import la32r_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] instruction
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata   // [1:0] status, [2] writes_register,
                                          // [7:3] dest_register,
                                          // [39:8] write_value, [71:40] next_pc
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RA   = 3'd1;
  localparam logic [2:0] S_RB   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EX   = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_WB   = 3'd7;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_MUL  = 2'd1;
  localparam logic [1:0] K_DIV  = 2'd2;

  localparam logic [21:0] OP_CNTID  = 22'h18;
  localparam logic [21:0] OP_CNTVH  = 22'h19;
  localparam logic [16:0] OP_ALU_LO = 17'h20;
  localparam logic [16:0] OP_ALU_HI = 17'h43;
  localparam logic [16:0] OP_ADD    = 17'h20;
  localparam logic [16:0] OP_SUB    = 17'h22;
  localparam logic [16:0] OP_SLT    = 17'h24;
  localparam logic [16:0] OP_SLTU   = 17'h25;
  localparam logic [16:0] OP_NOR    = 17'h28;
  localparam logic [16:0] OP_AND    = 17'h29;
  localparam logic [16:0] OP_OR     = 17'h2a;
  localparam logic [16:0] OP_XOR    = 17'h2b;
  localparam logic [16:0] OP_SLL    = 17'h2e;
  localparam logic [16:0] OP_SRL    = 17'h2f;
  localparam logic [16:0] OP_SRA    = 17'h30;
  localparam logic [16:0] OP_MUL    = 17'h38;
  localparam logic [16:0] OP_MULH   = 17'h39;
  localparam logic [16:0] OP_MULHU  = 17'h3a;
  localparam logic [16:0] OP_DIV    = 17'h40;
  localparam logic [16:0] OP_MOD    = 17'h41;
  localparam logic [16:0] OP_DIVU   = 17'h42;
  localparam logic [16:0] OP_MODU   = 17'h43;
  localparam logic [16:0] OP_BREAK  = 17'h54;
  localparam logic [16:0] OP_SYSC   = 17'h56;
  localparam logic [16:0] OP_SLLI   = 17'h81;
  localparam logic [16:0] OP_SRLI   = 17'h89;
  localparam logic [16:0] OP_SRAI   = 17'h91;
  localparam logic [16:0] OP_INVTLB = 17'hc93;
  localparam logic [16:0] OP_IDLE   = 17'hc91;
  localparam logic [16:0] OP_DBAR   = 17'h70e4;
  localparam logic [16:0] OP_IBAR   = 17'h70e5;
  localparam logic [9:0]  OP_SLTI   = 10'h8;
  localparam logic [9:0]  OP_SLTUI  = 10'h9;
  localparam logic [9:0]  OP_ADDI   = 10'ha;
  localparam logic [9:0]  OP_ANDI   = 10'hd;
  localparam logic [9:0]  OP_ORI    = 10'he;
  localparam logic [9:0]  OP_XORI   = 10'hf;
  localparam logic [9:0]  OP_CACOP  = 10'h018;
  localparam logic [9:0]  OP_LD_B   = 10'ha0;
  localparam logic [9:0]  OP_LD_W   = 10'ha2;
  localparam logic [9:0]  OP_ST_B   = 10'ha4;
  localparam logic [9:0]  OP_ST_W   = 10'ha6;
  localparam logic [9:0]  OP_LD_BU  = 10'ha8;
  localparam logic [9:0]  OP_LD_HU  = 10'ha9;
  localparam logic [9:0]  OP_PRELD  = 10'hab;
  localparam logic [7:0]  OP_CSR    = 8'h04;
  localparam logic [7:0]  OP_LL     = 8'h20;
  localparam logic [7:0]  OP_SC     = 8'h21;
  localparam logic [6:0]  OP_LU12I  = 7'h0a;
  localparam logic [6:0]  OP_PCADDU = 7'h0e;
  localparam logic [5:0]  OP_JIRL   = 6'h13;
  localparam logic [5:0]  OP_B      = 6'h14;
  localparam logic [5:0]  OP_BL     = 6'h15;
  localparam logic [5:0]  OP_BEQ    = 6'h16;
  localparam logic [5:0]  OP_BNE    = 6'h17;
  localparam logic [5:0]  OP_BLT    = 6'h18;
  localparam logic [5:0]  OP_BGE    = 6'h19;
  localparam logic [5:0]  OP_BLTU   = 6'h1a;
  localparam logic [5:0]  OP_BGEU   = 6'h1b;
  localparam logic [31:0] INS_TLBSRCH = 32'h0648_2800;
  localparam logic [31:0] INS_TLBRD   = 32'h0648_2c00;
  localparam logic [31:0] INS_TLBWR   = 32'h0648_3000;
  localparam logic [31:0] INS_TLBFILL = 32'h0648_3400;
  localparam logic [31:0] INS_ERTN    = 32'h0648_3800;

  logic [2:0]  state_q, state_d;
  logic [31:0] ins_q, pc_q, a_q, b_q;
  logic [31:0] gpr_vld_q, csr_vld_q;
  logic [4:0]  gpr_raddr_q, gpr_raddr;
  logic [31:0] gpr_rdata, csr_rdata, gpr_rval, csr_old;
  logic        gpr_we, csr_we;

  logic [1:0]  st_q;
  logic        wr_q, csr_we_q;
  logic [4:0]  dst_q, csr_slot_q;
  logic [31:0] val_q, next_q, csr_wd_q;
  logic [16:0] op17_q;
  logic [63:0] prod_q;

  logic        out_vld_q;
  logic [71:0] out_q;

  logic [4:0]  rd, rj, rk;
  logic [16:0] op17;
  logic [9:0]  op10;
  logic [7:0]  op8;
  logic [6:0]  op7;
  logic [5:0]  op6;
  logic [31:0] si12, ui12, off16, off26, d_w;
  csr_hit_t    csr_hit;
  logic [4:0]  csr_rslot;

  logic [1:0]  st;
  logic        wr, cwe, take;
  logic [4:0]  dst;
  logic [31:0] val, nxt, cwd, sel, merged, cmask;
  logic [1:0]  kind;

  div_req_t    div_req;
  logic        div_done;
  logic [31:0] div_res, mulh;
  logic        out_free;

  assign rd   = ins_q[4:0];
  assign rj   = ins_q[9:5];
  assign rk   = ins_q[14:10];
  assign op17 = ins_q[31:15];
  assign op10 = ins_q[31:22];
  assign op8  = ins_q[31:24];
  assign op7  = ins_q[31:25];
  assign op6  = ins_q[31:26];
  assign ui12  = {20'd0, ins_q[21:10]};
  assign si12  = {{20{ins_q[21]}}, ins_q[21:10]};
  assign off16 = {{14{ins_q[25]}}, ins_q[25:10], 2'b00};
  assign off26 = {{4{ins_q[9]}}, ins_q[9:0], ins_q[25:10], 2'b00};

  assign csr_hit   = csr_lookup(ins_q[23:10]);
  assign csr_rslot = (ins_q[31:10] == OP_CNTID) ? CSR_SLOT_TID : csr_hit.slot;
  assign cmask     = csr_wmask(csr_hit.slot);

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    case (state_q)
      S_RA:    gpr_raddr = rj;
      S_RB:    gpr_raddr = rk;
      default: gpr_raddr = rd;
    endcase
  end

  assign gpr_rval = (gpr_raddr_q == 5'd0 || !gpr_vld_q[gpr_raddr_q]) ? 32'd0 : gpr_rdata;
  assign d_w      = gpr_rval;
  assign csr_old  = csr_vld_q[csr_rslot] ? csr_rdata
                  : ((csr_rslot == CSR_SLOT_CRMD) ? CRMD_RESET : 32'd0);

  assign gpr_we = (state_q == S_WB) && out_free && wr_q;
  assign csr_we = (state_q == S_WB) && out_free && csr_we_q;

  la32r_ram #(.WIDTH(32), .DEPTH(32)) u_gpr (
    .clk_i   (clk_i),
    .we_i    (gpr_we),
    .waddr_i (dst_q),
    .wdata_i (val_q),
    .raddr_i (gpr_raddr),
    .rdata_o (gpr_rdata)
  );

  la32r_ram #(.WIDTH(32), .DEPTH(32)) u_csr (
    .clk_i   (clk_i),
    .we_i    (csr_we),
    .waddr_i (csr_slot_q),
    .wdata_i (csr_wd_q),
    .raddr_i (csr_rslot),
    .rdata_o (csr_rdata)
  );

  always_comb begin
    st     = ST_OK;
    wr     = 1'b0;
    dst    = rd;
    val    = 32'd0;
    nxt    = pc_q + 32'd4;
    kind   = K_NONE;
    cwe    = 1'b0;
    take   = 1'b0;
    sel    = (rj == 5'd1) ? 32'hffff_ffff : a_q;
    merged = (csr_old & ~sel) | (d_w & sel);
    cwd    = (csr_old & ~cmask) | (merged & cmask);
    if (ins_q[31:10] == OP_CNTID) begin
      if (rd == 5'd0) begin
        wr  = 1'b1;
        dst = rj;
        val = csr_old;
      end else if (rj == 5'd0) begin
        st = ST_UNSUP;
      end else begin
        st = ST_UNKNOWN;
      end
    end else if (ins_q[31:10] == OP_CNTVH) begin
      st = (rj == 5'd0) ? ST_UNSUP : ST_UNKNOWN;
    end else if (op17 >= OP_ALU_LO && op17 <= OP_ALU_HI) begin
      wr = 1'b1;
      case (op17)
        OP_ADD:  val = a_q + b_q;
        OP_SUB:  val = a_q - b_q;
        OP_SLT:  val = {31'd0, $signed(a_q) < $signed(b_q)};
        OP_SLTU: val = {31'd0, a_q < b_q};
        OP_NOR:  val = ~(a_q | b_q);
        OP_AND:  val = a_q & b_q;
        OP_OR:   val = a_q | b_q;
        OP_XOR:  val = a_q ^ b_q;
        OP_SLL:  val = a_q << b_q[4:0];
        OP_SRL:  val = a_q >> b_q[4:0];
        OP_SRA:  val = $unsigned($signed(a_q) >>> b_q[4:0]);
        OP_MUL, OP_MULH, OP_MULHU: kind = K_MUL;
        OP_DIV, OP_MOD, OP_DIVU, OP_MODU: begin
          if (b_q == 32'd0) begin
            val = (op17 == OP_MOD || op17 == OP_MODU) ? a_q : 32'd0;
          end else begin
            kind = K_DIV;
          end
        end
        default: begin
          wr = 1'b0;
          st = ST_UNKNOWN;
        end
      endcase
    end else if (op17 == OP_BREAK || op17 == OP_SYSC) begin
      st = ST_UNSUP;
    end else if (op17 == OP_SLLI || op17 == OP_SRLI || op17 == OP_SRAI) begin
      wr = 1'b1;
      if (op17 == OP_SLLI) begin
        val = a_q << rk;
      end else if (op17 == OP_SRLI) begin
        val = a_q >> rk;
      end else begin
        val = $unsigned($signed(a_q) >>> rk);
      end
    end else if (op10 == OP_SLTI || op10 == OP_SLTUI || op10 == OP_ADDI ||
                 op10 == OP_ANDI || op10 == OP_ORI || op10 == OP_XORI) begin
      wr = 1'b1;
      case (op10)
        OP_SLTI:  val = {31'd0, $signed(a_q) < $signed(si12)};
        OP_SLTUI: val = {31'd0, a_q < si12};
        OP_ADDI:  val = a_q + si12;
        OP_ANDI:  val = a_q & ui12;
        OP_ORI:   val = a_q | ui12;
        default:  val = a_q ^ ui12;
      endcase
    end else if (op8 == OP_CSR) begin
      if (!csr_hit.hit) begin
        st = ST_BADCSR;
      end else begin
        cwe = (rj != 5'd0);
        wr  = 1'b1;
        val = csr_old;
      end
    end else if (op10 == OP_CACOP) begin
      st = ST_UNSUP;
    end else if (ins_q == INS_TLBSRCH || ins_q == INS_TLBRD || ins_q == INS_TLBWR ||
                 ins_q == INS_TLBFILL || ins_q == INS_ERTN) begin
      st = ST_UNSUP;
    end else if (op17 == OP_IDLE || op17 == OP_INVTLB) begin
      st = ST_UNSUP;
    end else if (op7 == OP_LU12I) begin
      wr  = 1'b1;
      val = {ins_q[24:5], 12'd0};
    end else if (op7 == OP_PCADDU) begin
      wr  = 1'b1;
      val = pc_q + {ins_q[24:5], 12'd0};
    end else if (op8 == OP_LL || op8 == OP_SC) begin
      st = ST_UNSUP;
    end else if ((op10 >= OP_LD_B && op10 <= OP_LD_W) ||
                 (op10 >= OP_ST_B && op10 <= OP_ST_W) ||
                 op10 == OP_LD_BU || op10 == OP_LD_HU || op10 == OP_PRELD) begin
      st = ST_UNSUP;
    end else if (op17 == OP_DBAR || op17 == OP_IBAR) begin
      st = ST_UNSUP;
    end else if (op6 >= OP_JIRL && op6 <= OP_BGEU) begin
      case (op6)
        OP_JIRL: begin
          wr  = 1'b1;
          val = pc_q + 32'd4;
          nxt = a_q + off16;
        end
        OP_B:    nxt = pc_q + off26;
        OP_BL: begin
          wr  = 1'b1;
          dst = 5'd1;
          val = pc_q + 32'd4;
          nxt = pc_q + off26;
        end
        OP_BEQ:  take = (a_q == d_w);
        OP_BNE:  take = (a_q != d_w);
        OP_BLT:  take = $signed(a_q) < $signed(d_w);
        OP_BGE:  take = !($signed(a_q) < $signed(d_w));
        OP_BLTU: take = a_q < d_w;
        default: take = a_q >= d_w;
      endcase
      if (take) begin
        nxt = pc_q + off16;
      end
    end else begin
      st = ST_UNKNOWN;
    end
    if (st != ST_OK) begin
      wr   = 1'b0;
      cwe  = 1'b0;
      kind = K_NONE;
      nxt  = pc_q + 32'd4;
    end
    if (!wr || dst == 5'd0) begin
      wr   = 1'b0;
      dst  = 5'd0;
      val  = 32'd0;
      kind = K_NONE;
    end
  end

  assign div_req.start     = (state_q == S_EX) && (kind == K_DIV);
  assign div_req.is_signed = (op17 == OP_DIV || op17 == OP_MOD);
  assign div_req.want_mod  = (op17 == OP_MOD || op17 == OP_MODU);

  la32r_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .result_o   (div_res)
  );

  always_comb begin
    mulh = prod_q[63:32];
    if (op17_q == OP_MULH) begin
      mulh = prod_q[63:32] - (a_q[31] ? b_q : 32'd0) - (b_q[31] ? a_q : 32'd0);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_RA;
      S_RA:   state_d = S_RB;
      S_RB:   state_d = S_RD;
      S_RD:   state_d = S_EX;
      S_EX: begin
        case (kind)
          K_MUL:   state_d = S_MUL;
          K_DIV:   state_d = S_DIV;
          default: state_d = S_WB;
        endcase
      end
      S_MUL:  state_d = S_WB;
      S_DIV:  if (div_done) state_d = S_WB;
      S_WB:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= RESET_PC;
      gpr_vld_q <= 32'd0;
      csr_vld_q <= 32'd0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (gpr_we) begin
        gpr_vld_q[dst_q] <= 1'b1;
      end
      if (csr_we) begin
        csr_vld_q[csr_slot_q] <= 1'b1;
      end
      if ((state_q == S_WB) && out_free) begin
        pc_q      <= next_q;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gpr_raddr_q <= gpr_raddr;
    if (s_axis_tvalid && s_axis_tready) begin
      ins_q <= s_axis_tdata;
    end
    if (state_q == S_RB) begin
      a_q <= gpr_rval;
    end
    if (state_q == S_RD) begin
      b_q <= gpr_rval;
    end
    if (state_q == S_EX) begin
      st_q       <= st;
      wr_q       <= wr;
      dst_q      <= dst;
      val_q      <= val;
      next_q     <= nxt;
      csr_we_q   <= cwe;
      csr_wd_q   <= cwd;
      csr_slot_q <= csr_hit.slot;
      op17_q     <= op17;
      prod_q     <= {32'd0, a_q} * {32'd0, b_q};
    end
    if (state_q == S_MUL) begin
      val_q <= (op17_q == OP_MUL) ? prod_q[31:0] : mulh;
    end
    if (state_q == S_DIV && div_done) begin
      val_q <= div_res;
    end
    if ((state_q == S_WB) && out_free) begin
      out_q <= {next_q, val_q, dst_q, wr_q, st_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_gpr_no_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gpr_we |-> (dst_q != 5'd0))
    else $error("write-back to r0");

  a_pc_at_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(pc_q) |-> $past(state_q == S_WB))
    else $error("pc changed outside write-back");

  a_out_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_WB))
    else $error("result raised outside write-back");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> (state_q == S_DIV))
    else $error("divider started without waiting");

endmodule
`default_nettype wire

// ===== test/tb_la32r_integer_execute_unit.sv =====
`timescale 1ns / 1ps
module tb_la32r_integer_execute_unit;
  import la32r_pkg::*;

  localparam int CsrCount = 30;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;

  la32r_integer_execute_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  typedef struct packed {
    logic [31:0] next_pc;
    logic [31:0] write_value;
    logic [4:0]  dest_register;
    logic        writes_register;
    logic [1:0]  status;
  } exec_result_t;

  logic [31:0]  gpr_shadow [1:31];
  logic [31:0]  pc_shadow;
  logic [31:0]  csr_shadow [0:CsrCount-1];
  exec_result_t pending_results [$];
  int           error_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_off_cycles;

  localparam logic [13:0] CsrAddrs [0:CsrCount-1] = '{
    14'h000, 14'h001, 14'h002, 14'h004, 14'h005, 14'h006, 14'h007, 14'h00c,
    14'h010, 14'h011, 14'h012, 14'h013, 14'h018, 14'h019, 14'h01a, 14'h01b,
    14'h020, 14'h030, 14'h031, 14'h032, 14'h033, 14'h040, 14'h041, 14'h042,
    14'h044, 14'h060, 14'h088, 14'h098, 14'h180, 14'h181
  };

  localparam logic [31:0] WMasks [0:CsrCount-1] = '{
    32'h1ff, 32'h7, 32'h1, 32'h1bff, 32'h3, 32'hffffffff, 32'hffffffff,
    32'hffffffc0, 32'hbf00ffff, 32'hffffe000, 32'hffffff7f,
    32'hffffff7f, 32'h3ff, 32'hfffff000, 32'hfffff000, 32'h0, 32'h0,
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'h7fffffff, 32'h0, 32'h0, 32'h4, 32'hffffffc0, 32'h0, 32'hee000039,
    32'hee000039
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [31:0] gpr(input logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : gpr_shadow[idx];
  endfunction

  function automatic logic less_signed(input logic [31:0] x, input logic [31:0] y);
    return $signed(x) < $signed(y);
  endfunction

  function automatic logic [31:0] sdiv_or_mod(input logic [31:0] x, input logic [31:0] y,
                                              input logic want_mod);
    logic [31:0] ux, uy, q, r;
    if (y == 32'd0) return want_mod ? x : 32'd0;
    ux = x[31] ? -x : x;
    uy = y[31] ? -y : y;
    q = ux / uy;
    r = ux % uy;
    if (want_mod) return x[31] ? -r : r;
    return (x[31] ^ y[31]) ? -q : q;
  endfunction

  function automatic exec_result_t execute_instruction(input logic [31:0] ins);
    exec_result_t res;
    logic [31:0] pc, nxt, a, b, d, val, si12, ui12, off16, off26, old, sel, merged;
    logic [63:0] prod;
    logic [4:0]  rd, rj, rk, dst;
    logic [16:0] op17;
    logic [9:0]  op10;
    logic [7:0]  op8;
    logic [6:0]  op7;
    logic [5:0]  op6;
    logic [1:0]  st;
    logic        wr, take;
    int          slot;
    pc = pc_shadow;
    nxt = pc + 32'd4;
    st = ST_OK;
    wr = 1'b0;
    dst = 5'd0;
    val = 32'd0;
    take = 1'b0;
    slot = -1;
    rd = ins[4:0];
    rj = ins[9:5];
    rk = ins[14:10];
    a = gpr(rj);
    b = gpr(rk);
    d = gpr(rd);
    op17 = ins[31:15];
    op10 = ins[31:22];
    op8 = ins[31:24];
    op7 = ins[31:25];
    op6 = ins[31:26];
    ui12 = {20'd0, ins[21:10]};
    si12 = {{20{ins[21]}}, ins[21:10]};
    off16 = {{14{ins[25]}}, ins[25:10], 2'b00};
    off26 = {{4{ins[9]}}, ins[9:0], ins[25:10], 2'b00};
    prod = {32'd0, a} * {32'd0, b};
    if (ins[31:10] == 22'h18) begin
      if (rd == 5'd0) begin
        wr = 1'b1; dst = rj; val = csr_shadow[CSR_SLOT_TID];
      end else st = (rj == 5'd0) ? ST_UNSUP : ST_UNKNOWN;
    end else if (ins[31:10] == 22'h19) begin
      st = (rj == 5'd0) ? ST_UNSUP : ST_UNKNOWN;
    end else if (op17 >= 17'h20 && op17 <= 17'h43) begin
      wr = 1'b1; dst = rd;
      case (op17)
        17'h20: val = a + b;
        17'h22: val = a - b;
        17'h24: val = {31'd0, less_signed(a, b)};
        17'h25: val = {31'd0, a < b};
        17'h28: val = ~(a | b);
        17'h29: val = a & b;
        17'h2a: val = a | b;
        17'h2b: val = a ^ b;
        17'h2e: val = a << b[4:0];
        17'h2f: val = a >> b[4:0];
        17'h30: val = $signed(a) >>> b[4:0];
        17'h38: val = prod[31:0];
        17'h39: begin
          val = prod[63:32];
          if (a[31]) val = val - b;
          if (b[31]) val = val - a;
        end
        17'h3a: val = prod[63:32];
        17'h40: val = sdiv_or_mod(a, b, 1'b0);
        17'h41: val = sdiv_or_mod(a, b, 1'b1);
        17'h42: val = (b == 0) ? 32'd0 : a / b;
        17'h43: val = (b == 0) ? a : a % b;
        default: begin wr = 1'b0; st = ST_UNKNOWN; end
      endcase
    end else if (op17 == 17'h54 || op17 == 17'h56) begin
      st = ST_UNSUP;
    end else if (op17 == 17'h81 || op17 == 17'h89 || op17 == 17'h91) begin
      wr = 1'b1; dst = rd;
      if (op17 == 17'h81) val = a << rk;
      else if (op17 == 17'h89) val = a >> rk;
      else val = $signed(a) >>> rk;
    end else if (op10 inside {10'h8, 10'h9, 10'ha, 10'hd, 10'he, 10'hf}) begin
      wr = 1'b1; dst = rd;
      case (op10)
        10'h8: val = {31'd0, less_signed(a, si12)};
        10'h9: val = {31'd0, a < si12};
        10'ha: val = a + si12;
        10'hd: val = a & ui12;
        10'he: val = a | ui12;
        default: val = a ^ ui12;
      endcase
    end else if (op8 == 8'h04) begin
      for (int i = 0; i < CsrCount; i++) if (CsrAddrs[i] == ins[23:10]) slot = i;
      if (slot < 0) st = ST_BADCSR;
      else begin
        old = csr_shadow[slot];
        if (rj != 5'd0) begin
          sel = (rj == 5'd1) ? 32'hffffffff : a;
          merged = (old & ~sel) | (d & sel);
          csr_shadow[slot] = (old & ~WMasks[slot]) | (merged & WMasks[slot]);
        end
        wr = 1'b1; dst = rd; val = old;
      end
    end else if (op10 == 10'h018) begin
      st = ST_UNSUP;
    end else if (ins inside {32'h06482800, 32'h06482c00, 32'h06483000, 32'h06483400,
                             32'h06483800}) begin
      st = ST_UNSUP;
    end else if (op17 == 17'hc91 || op17 == 17'hc93) begin
      st = ST_UNSUP;
    end else if (op7 == 7'h0a) begin
      wr = 1'b1; dst = rd; val = {ins[24:5], 12'd0};
    end else if (op7 == 7'h0e) begin
      wr = 1'b1; dst = rd; val = pc + {ins[24:5], 12'd0};
    end else if (op8 == 8'h20 || op8 == 8'h21) begin
      st = ST_UNSUP;
    end else if ((op10 >= 10'ha0 && op10 <= 10'ha2) || (op10 >= 10'ha4 && op10 <= 10'ha6)
                 || op10 == 10'ha8 || op10 == 10'ha9 || op10 == 10'hab) begin
      st = ST_UNSUP;
    end else if (op17 == 17'h70e4 || op17 == 17'h70e5) begin
      st = ST_UNSUP;
    end else if (op6 >= 6'h13 && op6 <= 6'h1b) begin
      case (op6)
        6'h13: begin wr = 1'b1; dst = rd; val = pc + 32'd4; nxt = a + off16; end
        6'h14: nxt = pc + off26;
        6'h15: begin wr = 1'b1; dst = 5'd1; val = pc + 32'd4; nxt = pc + off26; end
        6'h16: take = (a == d);
        6'h17: take = (a != d);
        6'h18: take = less_signed(a, d);
        6'h19: take = !less_signed(a, d);
        6'h1a: take = (a < d);
        default: take = (a >= d);
      endcase
      if (take) nxt = pc + off16;
    end else begin
      st = ST_UNKNOWN;
    end
    if (st != ST_OK) begin
      wr = 1'b0;
      nxt = pc + 32'd4;
    end
    if (!wr || dst == 5'd0) begin
      wr = 1'b0; dst = 5'd0; val = 32'd0;
    end else gpr_shadow[dst] = val;
    pc_shadow = nxt;
    res.status = st;
    res.writes_register = wr;
    res.dest_register = dst;
    res.write_value = val;
    res.next_pc = nxt;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // drive receiver ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check each result item
  always @(posedge clk_i) begin
    exec_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", got.next_pc, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.writes_register != want.writes_register)
          report_mismatch("writes_register", 32'(got.writes_register),
                          32'(want.writes_register));
        if (got.dest_register != want.dest_register)
          report_mismatch("dest_register", 32'(got.dest_register),
                          32'(want.dest_register));
        if (got.write_value != want.write_value)
          report_mismatch("write_value", got.write_value, want.write_value);
        if (got.next_pc != want.next_pc)
          report_mismatch("next_pc", got.next_pc, want.next_pc);
      end
    end
  end

  task automatic send_instruction(input logic [31:0] ins);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= ins;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(execute_instruction(ins));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] reg3(input logic [16:0] op, input logic [4:0] k,
                                       input logic [4:0] j, input logic [4:0] d);
    return {op, k, j, d};
  endfunction

  // random instruction biased toward supported encodings
  function automatic logic [31:0] random_instruction();
    logic [4:0] k, j, d;
    int pick;
    k = 5'($urandom_range(31));
    j = 5'($urandom_range(31));
    d = 5'($urandom_range(31));
    pick = $urandom_range(99);
    if (pick < 35) return reg3(17'(17'h20 + $urandom_range(35)), k, j, d);
    if (pick < 45) return reg3(17'(17'h81 + 8 * $urandom_range(2)), k, j, d);
    if (pick < 58) return {6'h0, 4'(4'h8 + $urandom_range(7)), 12'($urandom_range(4095)),
                           j, d};
    if (pick < 64) return {7'(7'h0a + 4 * $urandom_range(1)), 20'($urandom()), d};
    if (pick < 72) return {8'h04, 14'(CsrAddrs[$urandom_range(CsrCount - 1)]), j, d};
    if (pick < 74) return {8'h04, 14'($urandom()), j, d};
    if (pick < 77) return {22'(22'h18 + $urandom_range(1)), j, d};
    if (pick < 90) return {6'(6'h13 + $urandom_range(8)), 26'($urandom())};
    return $urandom();
  endfunction

  task automatic test_directed();
    send_instruction(32'h02bffc01);        // addi r1, r0, -1
    send_instruction(32'h03bffc02);        // ori r2, r0, 0xfff
    send_instruction(32'h14fffffe);        // lu12i r30 0x7ffff
    send_instruction(32'h15000003);        // lu12i r3 0x80000
    send_instruction(reg3(17'h40, 5'd1, 5'd3, 5'd4));  // overflow div
    send_instruction(reg3(17'h41, 5'd1, 5'd3, 5'd5));
    send_instruction(reg3(17'h40, 5'd0, 5'd3, 5'd6));  // divide by zero
    send_instruction(reg3(17'h43, 5'd0, 5'd3, 5'd7));
    send_instruction(reg3(17'h42, 5'd0, 5'd1, 5'd7));
    send_instruction(reg3(17'h20, 5'd1, 5'd1, 5'd0));  // write to r0
    send_instruction(reg3(17'h39, 5'd1, 5'd3, 5'd8));
    send_instruction(reg3(17'h3a, 5'd1, 5'd1, 5'd8));
    send_instruction(32'h1c000009);        // pcaddu12i
    send_instruction({8'h04, 14'h006, 5'd1, 5'd1});    // csrwr
    send_instruction({8'h04, 14'h006, 5'd3, 5'd2});    // csrxchg by mask
    send_instruction({8'h04, 14'h006, 5'd0, 5'd9});    // csrrd
    send_instruction({8'h04, 14'h044, 5'd1, 5'd1});    // csrwr to 0x044, no writable bits
    send_instruction({8'h04, 14'h3fff, 5'd1, 5'd1});   // bad CSR
    send_instruction({22'h18, 5'd0, 5'd0});            // rdcntid to r0
    send_instruction({6'h13, 16'd4, 5'd10, 5'd10});    // jirl rd = rj
    send_instruction({6'h15, 16'd2, 10'd0});           // bl
    send_instruction({6'h16, 16'hfffe, 5'd0, 5'd0});   // beq backward
    send_instruction(32'h28800000);        // load, unsupported
    send_instruction(32'hffffffff);
    send_instruction(32'h00000000);
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_instruction(random_instruction());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 300;
    repeat (20) send_instruction(random_instruction());
    drain_results();
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    for (int i = 1; i < 32; i++) gpr_shadow[i] = 32'd0;
    for (int i = 0; i < CsrCount; i++) csr_shadow[i] = 32'd0;
    csr_shadow[CSR_SLOT_CRMD] = CRMD_RESET;
    pc_shadow = RESET_PC;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(220, 0, 0);
    test_random(220, 62, 0);
    test_backpressure();
    test_random(220, 0, 62);
    test_random(220, 30, 30);
    drain_results();
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/la32r_pkg.sv
src/la32r_ram.sv
src/la32r_div.sv
src/la32r_integer_execute_unit.sv
test/tb_la32r_integer_execute_unit.sv
